### src/psrl_pkg.sv
// Shared constants, state encoding and compare result type for the connect rate limiter.
package psrl_pkg;

   localparam int TABLE_ENTRIES_DEF    = 16;
   localparam int STAMPS_PER_ENTRY_DEF = 32;
   localparam int ADDR_W               = 32;
   localparam int TIME_W               = 32;
   localparam int RATE_W               = 8;
   localparam int COUNT_OUT_W          = 6;
   localparam int STAMP_WORD_W         = TIME_W + 1;
   localparam int WINDOW_SEC           = 4;
   localparam int RATE_SHIFT           = 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND,
      ST_CLEAR,
      ST_SCAN,
      ST_PUT
   } state_type;

   typedef struct packed {
      logic eq;
      logic late;
   } cmp_result_type;

endpackage

### src/psrl_ram.sv
// Generic single write port memory with one registered read port.
module psrl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/psrl_cmp.sv
// Shared compare unit: address match and window expiry test on one operand pair.
module psrl_cmp (
   input  logic [psrl_pkg::TIME_W-1:0] opnd_a,
   input  logic [psrl_pkg::TIME_W-1:0] opnd_b,
   output psrl_pkg::cmp_result_type    result
);
   import psrl_pkg::*;

   logic [TIME_W:0] a_plus_window;

   assign a_plus_window = {1'b0, opnd_a} + (TIME_W + 1)'(WINDOW_SEC);

   always_comb begin
      result.eq   = (opnd_a == opnd_b);
      result.late = (a_plus_window < {1'b0, opnd_b});
   end

endmodule

### src/per_source_connect_rate_limiter.sv
// Top level of the per-source connection rate limiter: sequencer, counters and memories.
//
// A connection event is offered on req_src_addr and req_now_sec with start and is taken
// at a clock edge where start is high and busy is low. The block then walks the address
// table one entry a cycle through the shared compare unit. On a hit it walks the stamp
// list of that entry one slot a cycle, drops expired stamps, counts the rest, tracks the
// lowest free slot and the oldest stamp, and writes the new stamp. A new address takes the
// next free entry, whose stamp list is cleared one slot a cycle first.
// An event on a hit passes through the find, scan and put states, a new address through
// the find, clear and put states, and an event that meets a full table ends after the
// find state. The word of the result appears on the rsp_ ports for one cycle with
// rsp_valid; the receiver cannot stall and must take it then. busy is high from the
// accepting edge until the result is registered, so a new event may be offered in the
// cycle the result is shown. csr_max_rate is written with csr_write_en while the block
// is idle: the user is bound to this, and the block itself does not enforce it. Reset
// empties the table and clears max_rate to zero; no clearing pass follows reset.
module per_source_connect_rate_limiter #(
   parameter int TABLE_ENTRIES    = psrl_pkg::TABLE_ENTRIES_DEF,
   parameter int STAMPS_PER_ENTRY = psrl_pkg::STAMPS_PER_ENTRY_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [psrl_pkg::ADDR_W-1:0]      req_src_addr,
   input  logic [psrl_pkg::TIME_W-1:0]      req_now_sec,
   output logic                             rsp_valid,
   output logic                             rsp_reject,
   output logic                             rsp_table_full,
   output logic [psrl_pkg::COUNT_OUT_W-1:0] rsp_recent_count,
   input  logic                             csr_write_en,
   input  logic [psrl_pkg::RATE_W-1:0]      csr_max_rate
);
   import psrl_pkg::*;

   localparam int EW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int EFW   = $clog2(TABLE_ENTRIES + 1);
   localparam int SW    = (STAMPS_PER_ENTRY > 1) ? $clog2(STAMPS_PER_ENTRY) : 1;
   localparam int SFW   = $clog2(STAMPS_PER_ENTRY + 1);
   localparam int SLOTS = TABLE_ENTRIES * STAMPS_PER_ENTRY;
   localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   state_type state_ff, state_in;

   logic [RATE_W-1:0]  max_rate_ff;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic [EFW-1:0]     fill_ff, fill_in;
   logic [EFW-1:0]     ent_iss_ff, ent_iss_in;
   logic [SFW-1:0]     slot_iss_ff, slot_iss_in;
   logic               chk_valid_ff, chk_valid_in;
   logic [EW-1:0]      chk_ent_ff, chk_ent_in;
   logic [SW-1:0]      chk_slot_ff, chk_slot_in;
   logic [AW-1:0]      base_ff, base_in;
   logic [SFW-1:0]     count_ff, count_in;
   logic               free_found_ff, free_found_in;
   logic [SW-1:0]      free_slot_ff, free_slot_in;
   logic               min_valid_ff, min_valid_in;
   logic [SW-1:0]      min_slot_ff, min_slot_in;
   logic [TIME_W-1:0]  min_time_ff, min_time_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_reject_ff, rsp_reject_in;
   logic               rsp_full_ff, rsp_full_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;

   logic                    ent_wr_en;
   logic [EW-1:0]           ent_wr_addr;
   logic [ADDR_W-1:0]       ent_rd_data;
   logic                    stamp_wr_en;
   logic [AW-1:0]           stamp_wr_addr;
   logic [STAMP_WORD_W-1:0] stamp_wr_data;
   logic [AW-1:0]           stamp_rd_addr;
   logic [STAMP_WORD_W-1:0] stamp_rd_data;

   logic [TIME_W-1:0] cmp_a, cmp_b;
   cmp_result_type    cmp_res;

   logic              accept;
   logic              find_hit, find_more, find_miss, table_is_full;
   logic              slot_more, scan_done, clear_last;
   logic              stamp_used, stamp_drop;
   logic [TIME_W-1:0] stamp_time;
   logic [SW-1:0]     pick_slot;

   psrl_ram #(
      .WIDTH (ADDR_W),
      .DEPTH (TABLE_ENTRIES),
      .AW    (EW)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (ent_wr_addr),
      .wr_data (addr_ff),
      .rd_addr (ent_iss_ff[EW-1:0]),
      .rd_data (ent_rd_data)
   );

   psrl_ram #(
      .WIDTH (STAMP_WORD_W),
      .DEPTH (SLOTS),
      .AW    (AW)
   ) u_stamp_ram (
      .clock   (clock),
      .wr_en   (stamp_wr_en),
      .wr_addr (stamp_wr_addr),
      .wr_data (stamp_wr_data),
      .rd_addr (stamp_rd_addr),
      .rd_data (stamp_rd_data)
   );

   psrl_cmp u_cmp (
      .opnd_a (cmp_a),
      .opnd_b (cmp_b),
      .result (cmp_res)
   );

   assign stamp_used = stamp_rd_data[STAMP_WORD_W-1];
   assign stamp_time = stamp_rd_data[TIME_W-1:0];
   assign cmp_a      = (state_ff == ST_SCAN) ? stamp_time : ent_rd_data;
   assign cmp_b      = (state_ff == ST_SCAN) ? now_ff : addr_ff;
   assign stamp_drop = stamp_used & cmp_res.late;

   assign accept        = start & (state_ff == ST_IDLE);
   assign find_hit      = chk_valid_ff & cmp_res.eq;
   assign find_more     = (ent_iss_ff < fill_ff);
   assign find_miss     = !chk_valid_ff && !find_more;
   assign table_is_full = (fill_ff == EFW'(TABLE_ENTRIES));
   assign slot_more     = (slot_iss_ff < SFW'(STAMPS_PER_ENTRY));
   assign scan_done     = !chk_valid_ff && !slot_more;
   assign clear_last    = (slot_iss_ff == SFW'(STAMPS_PER_ENTRY - 1));
   assign pick_slot     = free_found_ff ? free_slot_ff : min_slot_ff;
   assign stamp_rd_addr = base_ff + AW'(slot_iss_ff[SW-1:0]);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_FIND;
            end
         end
         ST_FIND: begin
            if (find_hit) begin
               state_in = ST_SCAN;
            end else if (find_miss) begin
               state_in = table_is_full ? ST_IDLE : ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            if (clear_last) begin
               state_in = ST_PUT;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_PUT;
            end
         end
         ST_PUT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      addr_in       = addr_ff;
      now_in        = now_ff;
      fill_in       = fill_ff;
      ent_iss_in    = ent_iss_ff;
      slot_iss_in   = slot_iss_ff;
      chk_valid_in  = 1'b0;
      chk_ent_in    = chk_ent_ff;
      chk_slot_in   = chk_slot_ff;
      base_in       = base_ff;
      count_in      = count_ff;
      free_found_in = free_found_ff;
      free_slot_in  = free_slot_ff;
      min_valid_in  = min_valid_ff;
      min_slot_in   = min_slot_ff;
      min_time_in   = min_time_ff;
      rsp_valid_in  = 1'b0;
      rsp_reject_in = rsp_reject_ff;
      rsp_full_in   = rsp_full_ff;
      rsp_count_in  = rsp_count_ff;
      ent_wr_en     = 1'b0;
      ent_wr_addr   = fill_ff[EW-1:0];
      stamp_wr_en   = 1'b0;
      stamp_wr_addr = base_ff + AW'(chk_slot_ff);
      stamp_wr_data = {1'b0, stamp_time};
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               addr_in    = req_src_addr;
               now_in     = req_now_sec;
               ent_iss_in = '0;
            end
         end
         ST_FIND: begin
            if (find_hit) begin
               base_in       = AW'(32'(chk_ent_ff) * 32'(STAMPS_PER_ENTRY));
               slot_iss_in   = '0;
               count_in      = '0;
               free_found_in = 1'b0;
               min_valid_in  = 1'b0;
            end else if (find_miss) begin
               if (table_is_full) begin
                  rsp_valid_in  = 1'b1;
                  rsp_reject_in = 1'b0;
                  rsp_full_in   = 1'b1;
                  rsp_count_in  = '0;
               end else begin
                  ent_wr_en     = 1'b1;
                  fill_in       = fill_ff + EFW'(1);
                  base_in       = AW'(32'(fill_ff) * 32'(STAMPS_PER_ENTRY));
                  slot_iss_in   = '0;
                  count_in      = '0;
                  free_found_in = 1'b1;
                  free_slot_in  = '0;
               end
            end else if (find_more) begin
               ent_iss_in   = ent_iss_ff + EFW'(1);
               chk_valid_in = 1'b1;
               chk_ent_in   = ent_iss_ff[EW-1:0];
            end
         end
         ST_CLEAR: begin
            stamp_wr_en   = 1'b1;
            stamp_wr_addr = stamp_rd_addr;
            stamp_wr_data = '0;
            slot_iss_in   = slot_iss_ff + SFW'(1);
         end
         ST_SCAN: begin
            if (chk_valid_ff) begin
               if (stamp_drop) begin
                  stamp_wr_en = 1'b1;
               end
               if (!stamp_used || stamp_drop) begin
                  if (!free_found_ff) begin
                     free_found_in = 1'b1;
                     free_slot_in  = chk_slot_ff;
                  end
               end else begin
                  count_in = count_ff + SFW'(1);
                  if (!min_valid_ff || (stamp_time < min_time_ff)) begin
                     min_valid_in = 1'b1;
                     min_slot_in  = chk_slot_ff;
                     min_time_in  = stamp_time;
                  end
               end
            end
            if (slot_more) begin
               slot_iss_in  = slot_iss_ff + SFW'(1);
               chk_valid_in = 1'b1;
               chk_slot_in  = slot_iss_ff[SW-1:0];
            end
         end
         ST_PUT: begin
            stamp_wr_en   = 1'b1;
            stamp_wr_addr = base_ff + AW'(pick_slot);
            stamp_wr_data = {1'b1, now_ff};
            rsp_valid_in  = 1'b1;
            rsp_reject_in = (32'(count_ff >> RATE_SHIFT) > 32'(max_rate_ff));
            rsp_full_in   = 1'b0;
            rsp_count_in  = COUNT_OUT_W'(count_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         max_rate_ff  <= '0;
         fill_ff      <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            max_rate_ff <= csr_max_rate;
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      now_ff        <= now_in;
      ent_iss_ff    <= ent_iss_in;
      slot_iss_ff   <= slot_iss_in;
      chk_ent_ff    <= chk_ent_in;
      chk_slot_ff   <= chk_slot_in;
      base_ff       <= base_in;
      count_ff      <= count_in;
      free_found_ff <= free_found_in;
      free_slot_ff  <= free_slot_in;
      min_valid_ff  <= min_valid_in;
      min_slot_ff   <= min_slot_in;
      min_time_ff   <= min_time_in;
      rsp_reject_ff <= rsp_reject_in;
      rsp_full_ff   <= rsp_full_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_reject       = rsp_reject_ff;
   assign rsp_table_full   = rsp_full_ff;
   assign rsp_recent_count = rsp_count_ff;

endmodule

### verif/tb.sv
// Self-checking testbench for the per-source connection rate limiter.
`timescale 1ns / 1ps

module tb;

   import psrl_pkg::*;

   localparam int N_ENT         = TABLE_ENTRIES_DEF;
   localparam int N_STAMP       = STAMPS_PER_ENTRY_DEF;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic                   reject;
      logic                   table_full;
      logic [COUNT_OUT_W-1:0] recent_count;
   } conn_verdict_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [ADDR_W-1:0]      req_src_addr;
   logic [TIME_W-1:0]      req_now_sec;
   logic                   rsp_valid;
   logic                   rsp_reject;
   logic                   rsp_table_full;
   logic [COUNT_OUT_W-1:0] rsp_recent_count;
   logic                   csr_write_en;
   logic [RATE_W-1:0]      csr_max_rate;

   bit                ent_used [N_ENT];
   logic [ADDR_W-1:0] ent_addr [N_ENT];
   logic [TIME_W-1:0] stamp_t [N_ENT][N_STAMP];
   bit                stamp_u [N_ENT][N_STAMP];
   logic [RATE_W-1:0] rate_limit = '0;

   conn_verdict_type  verdict_q [$];
   int                mismatch_count = 0;
   int                events_sent = 0;
   int                idle_cycles = 0;
   bit                gap_enable = 1'b0;
   logic [TIME_W-1:0] sec_clock = '0;

   per_source_connect_rate_limiter i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_src_addr     (req_src_addr),
      .req_now_sec      (req_now_sec),
      .rsp_valid        (rsp_valid),
      .rsp_reject       (rsp_reject),
      .rsp_table_full   (rsp_table_full),
      .rsp_recent_count (rsp_recent_count),
      .csr_write_en     (csr_write_en),
      .csr_max_rate     (csr_max_rate)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void store_stamp(input int e, input logic [TIME_W-1:0] now);
      int pick;
      pick = -1;
      for (int s = 0; s < N_STAMP; s++)
         if (pick < 0 && !stamp_u[e][s]) pick = s;
      if (pick < 0) begin
         pick = 0;
         for (int s = 1; s < N_STAMP; s++)
            if (stamp_t[e][s] < stamp_t[e][pick]) pick = s;
      end
      stamp_u[e][pick] = 1'b1;
      stamp_t[e][pick] = now;
   endfunction

   function automatic conn_verdict_type predict_connect(input logic [ADDR_W-1:0] addr,
                                                        input logic [TIME_W-1:0] now);
      conn_verdict_type v;
      int hit;
      int fr;
      int n;
      v = '0;
      hit = -1;
      fr = -1;
      n = 0;
      for (int e = 0; e < N_ENT; e++)
         if (hit < 0 && ent_used[e] && ent_addr[e] == addr) hit = e;
      if (hit >= 0) begin
         for (int s = 0; s < N_STAMP; s++) begin
            if (stamp_u[hit][s]) begin
               if ({1'b0, stamp_t[hit][s]} + 33'(WINDOW_SEC) < {1'b0, now})
                  stamp_u[hit][s] = 1'b0;
               else
                  n++;
            end
         end
         v.recent_count = n[COUNT_OUT_W-1:0];
         v.reject = ((n >> RATE_SHIFT) > rate_limit);
         store_stamp(hit, now);
      end else begin
         for (int e = 0; e < N_ENT; e++)
            if (fr < 0 && !ent_used[e]) fr = e;
         if (fr >= 0) begin
            ent_used[fr] = 1'b1;
            ent_addr[fr] = addr;
            for (int s = 0; s < N_STAMP; s++) stamp_u[fr][s] = 1'b0;
            store_stamp(fr, now);
         end else begin
            v.table_full = 1'b1;
         end
      end
      return v;
   endfunction

   function automatic void report_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%s", msg);
   endfunction

   // Called at a falling edge; returns at the falling edge after the word is taken.
   task automatic send_connect(input logic [ADDR_W-1:0] addr, input logic [TIME_W-1:0] now);
      if (gap_enable && $urandom_range(0, 2) == 0) begin
         start = 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_src_addr = addr;
      req_now_sec  = now;
      start        = 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      verdict_q.push_back(predict_connect(addr, now));
      events_sent++;
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic write_max_rate(input logic [RATE_W-1:0] value);
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
      csr_write_en = 1'b1;
      csr_max_rate = value;
      @(negedge clock);
      csr_write_en = 1'b0;
      rate_limit   = value;
   endtask

   task automatic test_window_edge();
      send_connect(32'h0000_0000, 32'd0);
      send_connect(32'h0000_0000, 32'd1);
      send_connect(32'h0000_0000, 32'd2);
      send_connect(32'h0000_0000, 32'd7);
      send_connect(32'h0000_0000, 32'd11);
      send_connect(32'h0000_0000, 32'd12);
      send_connect(32'h0000_0000, 32'd3);
      send_connect(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_connect(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_connect(32'hFFFF_FFFF, 32'd0);
      send_connect(32'hFFFF_FFFF, 32'hFFFF_FFFB);
   endtask

   task automatic test_reject_threshold();
      repeat (6) send_connect(32'h5A5A_A5A5, 32'h8000_0000);
   endtask

   task automatic test_table_full();
      for (int e = 0; e < N_ENT; e++)
         if (!ent_used[e]) send_connect($urandom, $urandom);
      send_connect(32'hA5A5_5A5A, 32'h1234_5678);
      send_connect($urandom, $urandom);
   endtask

   task automatic test_random_traffic(input logic [RATE_W-1:0] rate, input int n_events,
                                      input bit gaps);
      int sent;
      int burst;
      int pick;
      logic [ADDR_W-1:0] addr;
      write_max_rate(rate);
      sent = 0;
      case ($urandom_range(0, 3))
         0: sec_clock = $urandom_range(0, 8);
         1: sec_clock = 32'hFFFF_FFFF - $urandom_range(0, 300);
         default: sec_clock = $urandom;
      endcase
      while (sent < n_events) begin
         gap_enable = gaps && ($urandom_range(0, 1) == 1);
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            burst = $urandom_range(1, 40);
            addr = ent_addr[$urandom_range(0, N_ENT - 1)];
            repeat (burst) begin
               send_connect(addr, sec_clock + $urandom_range(0, 2));
               if ($urandom_range(0, 7) == 0) sec_clock += 1;
            end
            sent += burst;
            sec_clock += $urandom_range(0, 6);
         end else if (pick < 85) begin
            send_connect(ent_addr[$urandom_range(0, N_ENT - 1)], $urandom);
            sent++;
         end else if (pick < 95) begin
            send_connect($urandom, sec_clock);
            sent++;
         end else begin
            if ($urandom_range(0, 1) == 1)
               send_connect(ent_addr[$urandom_range(0, N_ENT - 1)], $urandom_range(0, 7));
            else
               send_connect(ent_addr[$urandom_range(0, N_ENT - 1)],
                            32'hFFFF_FFFF - $urandom_range(0, 7));
            sent++;
         end
      end
      gap_enable = 1'b0;
   endtask

   always @(posedge clock) begin
      conn_verdict_type want;
      if (!reset && rsp_valid) begin
         if (verdict_q.size() == 0) begin
            report_error($sformatf("unexpected result word: reject=%0b full=%0b count=%0d",
                                   rsp_reject, rsp_table_full, rsp_recent_count));
         end else begin
            want = verdict_q.pop_front();
            if (rsp_reject !== want.reject || rsp_table_full !== want.table_full ||
                rsp_recent_count !== want.recent_count)
               report_error($sformatf({"mismatch: expected reject=%0b full=%0b count=%0d,",
                                       " got reject=%0b full=%0b count=%0d"},
                                      want.reject, want.table_full, want.recent_count,
                                      rsp_reject, rsp_table_full, rsp_recent_count));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d events", events_sent);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      reset        = 1'b1;
      start        = 1'b0;
      req_src_addr = '0;
      req_now_sec  = '0;
      csr_write_en = 1'b0;
      csr_max_rate = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_window_edge();
      test_reject_threshold();
      test_table_full();
      test_random_traffic(8'd255, 235, 1'b1);
      test_random_traffic(8'd1, 235, 1'b1);
      test_random_traffic(8'd0, 235, 1'b1);
      test_random_traffic(8'd8, 235, 1'b1);
      test_random_traffic(8'd7, 235, 1'b1);
      test_random_traffic(8'd2, 235, 1'b1);
      test_random_traffic($urandom_range(0, 255), 235, 1'b1);
      test_random_traffic(8'd3, 235, 1'b0);

      while (verdict_q.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (mismatch_count == 0 && verdict_q.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
